/* design/last_input_priority_key_cleaner_macros.svh */
// Assertion macros shared by the key cleaner checker.
`ifndef LAST_INPUT_PRIORITY_KEY_CLEANER_MACROS_SVH
`define LAST_INPUT_PRIORITY_KEY_CLEANER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LIPKC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lipkc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LIPKC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lipkc assertion failed");

`endif

/* design/lipkc_pkg.sv */
// Shared types and constants of the key cleaner.
package lipkc_pkg;

    localparam int SLOT_COUNT = 4;
    localparam int CODE_W     = 32;
    localparam int STAMP_W    = 48;
    localparam int SIZE_W     = 3;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [SIZE_W-1:0] GROUP_SIZE_RESET = 3'd2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_GROUP_SIZE  = 3'd0,
        REG_CODE_SLOT_0 = 3'd1,
        REG_CODE_SLOT_1 = 3'd2,
        REG_CODE_SLOT_2 = 3'd3,
        REG_CODE_SLOT_3 = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_DECIDE,
        ST_PRESS,
        ST_DROP,
        ST_REPRESS
    } state_t;

    typedef struct packed {
        logic load;
        logic match;
        logic decide;
        logic emit_other;
        logic emit_press;
        logic emit_self;
        logic emit_repress;
    } dp_cmd_t;

    typedef struct packed {
        logic found;
        logic press;
        logic idx_active;
        logic any_active;
        logic pending_any;
        logic held_any;
        logic slot_free;
    } dp_status_t;

endpackage

/* design/last_input_priority_key_cleaner.sv */
// Top level of the last-input-priority key cleaner.
// Usage:
//   Input channel (in_valid/in_ready) takes one key event per beat: operation
//   (1 press, 0 release), key_code and a 48-bit stamp. Output channel
//   (out_valid/out_ready) gives logical press/release beats carrying the
//   input stamp; last_of_run marks the final beat caused by one event.
//   Codes outside the configured group give no beats at all.
//   Configuration goes through the APB-style port: group_size at 0x00,
//   code slots 0..3 at 0x04..0x10. Write only while the block is idle.
// Timing:
//   An event is taken in the idle state, matched against the slots in
//   ST_MATCH and updates the held flags in ST_DECIDE; it then emits up to
//   four beats, one per cycle while the output register is free. A release
//   that finds no key active and none held gives no beats; one event at
//   a time.
// Reset: rst_n clears all held/active flags, drops out_valid and returns
//   group_size to 2 and all code slots to 0.
// Stall:
//   A waiting beat holds in the output register; the controller stops
//   at the next emission until the register frees, and in_ready stays low.
module last_input_priority_key_cleaner #(
    parameter int MAX_KEYS = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lipkc_pkg::ADDR_W-1:0]    paddr,
    input  logic [lipkc_pkg::DATA_W-1:0]    pwdata,
    output logic [lipkc_pkg::DATA_W-1:0]    prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            operation,
    input  logic [lipkc_pkg::CODE_W-1:0]    key_code,
    input  logic [lipkc_pkg::STAMP_W-1:0]   stamp,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [lipkc_pkg::CODE_W-1:0]    out_code,
    output logic                            out_pressed,
    output logic [lipkc_pkg::STAMP_W-1:0]   out_stamp,
    output logic                            last_of_run
);
    import lipkc_pkg::*;

    // Only flags that a slot can reach are built.
    localparam int KEYS = (MAX_KEYS < SLOT_COUNT) ? MAX_KEYS : SLOT_COUNT;

    logic [SIZE_W-1:0] group_size;
    logic [CODE_W-1:0] code_slot [SLOT_COUNT];
    dp_cmd_t           cmd;
    dp_status_t        status;

    lipkc_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .group_size (group_size),
        .code_slot  (code_slot)
    );

    lipkc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lipkc_datapath #(
        .KEYS (KEYS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .operation   (operation),
        .key_code    (key_code),
        .stamp       (stamp),
        .group_size  (group_size),
        .code_slot   (code_slot),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .out_code    (out_code),
        .out_pressed (out_pressed),
        .out_stamp   (out_stamp),
        .last_of_run (last_of_run)
    );

endmodule

/* design/lipkc_regs.sv */
// Configuration register file behind the APB-style port.
module lipkc_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lipkc_pkg::ADDR_W-1:0]        paddr,
    input  logic [lipkc_pkg::DATA_W-1:0]        pwdata,
    output logic [lipkc_pkg::DATA_W-1:0]        prdata,
    output logic                                pready,
    output logic [lipkc_pkg::SIZE_W-1:0]        group_size,
    output logic [lipkc_pkg::CODE_W-1:0]        code_slot [lipkc_pkg::SLOT_COUNT]
);
    import lipkc_pkg::*;

    logic [SIZE_W-1:0] group_size_reg;
    logic [SIZE_W-1:0] group_size_next;
    logic [CODE_W-1:0] code_slot_reg  [SLOT_COUNT];
    logic [CODE_W-1:0] code_slot_next [SLOT_COUNT];
    reg_idx_t          reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        group_size_next = group_size_reg;
        code_slot_next  = code_slot_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_GROUP_SIZE:  group_size_next   = pwdata[SIZE_W-1:0];
                REG_CODE_SLOT_0: code_slot_next[0] = pwdata[CODE_W-1:0];
                REG_CODE_SLOT_1: code_slot_next[1] = pwdata[CODE_W-1:0];
                REG_CODE_SLOT_2: code_slot_next[2] = pwdata[CODE_W-1:0];
                REG_CODE_SLOT_3: code_slot_next[3] = pwdata[CODE_W-1:0];
                default:         group_size_next   = group_size_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg <= GROUP_SIZE_RESET;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                code_slot_reg[i] <= '0;
            end
        end
        else
        begin
            group_size_reg <= group_size_next;
            code_slot_reg  <= code_slot_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_GROUP_SIZE:  prdata = DATA_W'(group_size_reg);
            REG_CODE_SLOT_0: prdata = code_slot_reg[0];
            REG_CODE_SLOT_1: prdata = code_slot_reg[1];
            REG_CODE_SLOT_2: prdata = code_slot_reg[2];
            REG_CODE_SLOT_3: prdata = code_slot_reg[3];
            default:         prdata = '0;
        endcase
    end

    assign group_size = group_size_reg;
    assign code_slot  = code_slot_reg;

endmodule

/* design/lipkc_datapath.sv */
// Datapath: event registers, key flags, slot match and the output register.
module lipkc_datapath #(
    parameter int KEYS = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            operation,
    input  logic [lipkc_pkg::CODE_W-1:0]    key_code,
    input  logic [lipkc_pkg::STAMP_W-1:0]   stamp,
    input  logic [lipkc_pkg::SIZE_W-1:0]    group_size,
    input  logic [lipkc_pkg::CODE_W-1:0]    code_slot [lipkc_pkg::SLOT_COUNT],
    input  lipkc_pkg::dp_cmd_t              cmd,
    output lipkc_pkg::dp_status_t           status,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [lipkc_pkg::CODE_W-1:0]    out_code,
    output logic                            out_pressed,
    output logic [lipkc_pkg::STAMP_W-1:0]   out_stamp,
    output logic                            last_of_run
);
    import lipkc_pkg::*;

    localparam int KEY_W = $clog2(KEYS);

    function automatic logic [KEY_W-1:0] lowest(input logic [KEYS-1:0] v);
        logic [KEY_W-1:0] idx;
        idx = '0;
        for (int i = KEYS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = KEY_W'(i);
            end
        end
        return idx;
    endfunction

    logic                op_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [STAMP_W-1:0]  stamp_reg;
    logic [KEY_W-1:0]    idx_reg;
    logic                found_reg;
    logic [KEYS-1:0]     held_reg;
    logic [KEYS-1:0]     held_next;
    logic [KEYS-1:0]     active_reg;
    logic [KEYS-1:0]     active_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [CODE_W-1:0]   out_code_reg;
    logic [CODE_W-1:0]   out_code_next;
    logic                out_pressed_reg;
    logic                out_pressed_next;
    logic [STAMP_W-1:0]  out_stamp_reg;
    logic                last_reg;
    logic                last_next;

    logic [CODE_W-1:0]   slot_code [KEYS];
    logic [SIZE_W-1:0]   used_cnt;
    logic [KEYS-1:0]     used_mask;
    logic                match_found;
    logic [KEY_W-1:0]    match_idx;
    logic [KEYS-1:0]     idx_onehot;
    logic [KEYS-1:0]     pending;
    logic [KEYS-1:0]     held_used;
    logic [KEY_W-1:0]    pend_idx;
    logic [KEY_W-1:0]    held_idx;
    logic                emit;

    always_comb
    begin
        for (int i = 0; i < KEYS; i++)
        begin
            slot_code[i] = code_slot[i];
        end
    end

    // Saturate the slot count to the slots that exist.
    assign used_cnt = (group_size > SIZE_W'(KEYS)) ? SIZE_W'(KEYS) : group_size;

    always_comb
    begin
        for (int i = 0; i < KEYS; i++)
        begin
            used_mask[i] = (SIZE_W'(i) < used_cnt);
        end
    end

    // Lowest matching slot wins.
    always_comb
    begin
        match_found = 1'b0;
        match_idx   = '0;
        for (int i = KEYS - 1; i >= 0; i--)
        begin
            if (used_mask[i] && (slot_code[i] == code_reg))
            begin
                match_found = 1'b1;
                match_idx   = KEY_W'(i);
            end
        end
    end

    assign idx_onehot = {{(KEYS-1){1'b0}}, 1'b1} << idx_reg;
    assign pending    = active_reg & ~idx_onehot & used_mask;
    assign held_used  = held_reg & used_mask;
    assign pend_idx   = lowest(pending);
    assign held_idx   = lowest(held_used);
    assign emit       = cmd.emit_other || cmd.emit_press || cmd.emit_self || cmd.emit_repress;

    always_comb
    begin
        held_next = held_reg;
        if (cmd.decide && found_reg)
        begin
            held_next[idx_reg] = op_reg;
        end
    end

    always_comb
    begin
        active_next      = active_reg;
        out_code_next    = out_code_reg;
        out_pressed_next = out_pressed_reg;
        last_next        = last_reg;
        if (cmd.emit_other)
        begin
            active_next[pend_idx] = 1'b0;
            out_code_next         = slot_code[pend_idx];
            out_pressed_next      = 1'b0;
            last_next             = 1'b0;
        end
        else if (cmd.emit_press)
        begin
            active_next[idx_reg] = 1'b1;
            out_code_next        = code_reg;
            out_pressed_next     = 1'b1;
            last_next            = 1'b1;
        end
        else if (cmd.emit_self)
        begin
            active_next[idx_reg] = 1'b0;
            out_code_next        = code_reg;
            out_pressed_next     = 1'b0;
            last_next            = !(|held_used);
        end
        else if (cmd.emit_repress)
        begin
            active_next[held_idx] = 1'b1;
            out_code_next         = slot_code[held_idx];
            out_pressed_next      = 1'b1;
            last_next             = 1'b1;
        end
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= 1'b0;
            held_reg      <= '0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.match)
            begin
                found_reg <= match_found;
            end
            held_reg      <= held_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= operation;
            code_reg  <= key_code;
            stamp_reg <= stamp;
        end
        if (cmd.match)
        begin
            idx_reg <= match_idx;
        end
        if (emit)
        begin
            out_stamp_reg <= stamp_reg;
        end
        out_code_reg    <= out_code_next;
        out_pressed_reg <= out_pressed_next;
        last_reg        <= last_next;
    end

    assign status.found       = found_reg;
    assign status.press       = op_reg;
    assign status.idx_active  = active_reg[idx_reg];
    assign status.any_active  = |(active_reg & used_mask);
    assign status.pending_any = |pending;
    assign status.held_any    = |held_used;
    assign status.slot_free   = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_code    = out_code_reg;
    assign out_pressed = out_pressed_reg;
    assign out_stamp   = out_stamp_reg;
    assign last_of_run = last_reg;

endmodule

/* design/lipkc_ctrl.sv */
// Controller: sequences match, flag update and result emission.
module lipkc_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  lipkc_pkg::dp_status_t   status,
    output lipkc_pkg::dp_cmd_t      cmd
);
    import lipkc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (!status.found)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.press)
                begin
                    state_next = ST_PRESS;
                end
                else if (status.idx_active)
                begin
                    state_next = ST_DROP;
                end
                else if (!status.any_active)
                begin
                    state_next = ST_REPRESS;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PRESS:
            begin
                if (status.slot_free)
                begin
                    if (status.pending_any)
                    begin
                        cmd.emit_other = 1'b1;
                    end
                    else
                    begin
                        cmd.emit_press = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            ST_DROP:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_self = 1'b1;
                    state_next    = status.held_any ? ST_REPRESS : ST_IDLE;
                end
            end
            ST_REPRESS:
            begin
                if (!status.held_any)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.slot_free)
                begin
                    cmd.emit_repress = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* design/lipkc_checker.sv */
// Port-level checker for the key cleaner, bound to the top level.
`include "last_input_priority_key_cleaner_macros.svh"

module lipkc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [lipkc_pkg::CODE_W-1:0]    out_code,
    input logic                            out_pressed,
    input logic [lipkc_pkg::STAMP_W-1:0]   out_stamp,
    input logic                            last_of_run
);
    // A stalled beat holds.
    `LIPKC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_code) && $stable(out_pressed) && $stable(out_stamp) && $stable(last_of_run))

    // One event at a time: input closes right after a beat is taken.
    `LIPKC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // An unfinished run keeps the input closed.
    `LIPKC_ASSERT_IMPL(a_run_blocks_input, clk, rst_n, out_valid && !last_of_run, !in_ready)

    // No beat appears out of an idle, empty block.
    `LIPKC_ASSERT_NEXT(a_no_spurious_beat, clk, rst_n, in_ready && !out_valid, !out_valid)

endmodule

bind last_input_priority_key_cleaner lipkc_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_code    (out_code),
    .out_pressed (out_pressed),
    .out_stamp   (out_stamp),
    .last_of_run (last_of_run)
);
